@@ hdl/bmhq_pkg.sv @@
// Shared types and codes for the binary min-heap queue.
package bmhq_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned TOTAL_W  = 7;
    localparam int unsigned STATUS_W = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                       command;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  removed_value;
        logic signed [VALUE_W-1:0]  head_value;
        logic        [TOTAL_W-1:0]  entry_total;
        logic        [STATUS_W-1:0] status;
    } t_res_word;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                       ins;
        logic                       ext;
        logic signed [VALUE_W-1:0]  key;
    } t_cell_ctl;

endpackage

@@ hdl/bmhq_if.sv @@
// Valid/ready channels for command and result words.
interface bmhq_cmd_if
    import bmhq_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cmd_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface bmhq_res_if
    import bmhq_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

@@ hdl/bmhq_cell.sv @@
// One slot of the sorted cell row: shifts right on insert, left on extract.
module bmhq_cell
    import bmhq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_prev_used,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic                      i_used,
    input  logic signed [VALUE_W-1:0] i_next_value,
    output logic signed [VALUE_W-1:0] o_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            // left neighbor larger: it moves in; else key lands at first larger/free slot
            if (i_prev_used && (i_ctl.key < i_prev_value)) begin
                n_value = i_prev_value;
            end else if (!i_used || (i_ctl.key < r_value)) begin
                n_value = i_ctl.key;
            end
        end else if (i_ctl.ext) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ hdl/binary_min_heap_queue.sv @@
// Min priority queue of signed 32-bit values built as a sorted row of DEPTH cells.
// Result word is valid in the cycle after the command word is accepted.
// One command per cycle unless a held result stalls; every cell updates in parallel.
// Reset: synchronous active-low; clears the entry count and the result valid flag.
// Cell contents are undefined after reset; only slots below the count are ever read.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bmhq_cmd_if.sink          i_cmd,
    bmhq_res_if.source        o_res
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Row of cells kept in ascending order; cell 0 holds the minimum.
    logic signed [VALUE_W-1:0] w_val  [DEPTH];
    logic                      w_used [DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_res_word        r_res;
    t_res_word        n_res;
    t_cell_ctl        w_ctl;
    logic             w_fire;
    logic             w_full;
    logic             w_empty;

    // Next command is taken as soon as the result register frees up.
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_fire      = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_ctl.ins = w_fire && (i_cmd.word.command == CMD_INSERT) && !w_full;
        w_ctl.ext = w_fire && (i_cmd.word.command == CMD_EXTRACT) && !w_empty;
        w_ctl.key = i_cmd.word.value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                      w_prev_used;
            logic signed [VALUE_W-1:0] w_prev_val;
            logic signed [VALUE_W-1:0] w_next_val;

            assign w_used[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign w_prev_used = 1'b0;
                assign w_prev_val  = '0;
            end else begin : g_mid
                assign w_prev_used = w_used[gi-1];
                assign w_prev_val  = w_val[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_next_val = '0;
            end else begin : g_inner
                assign w_next_val = w_val[gi+1];
            end

            bmhq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_prev_used  (w_prev_used),
                .i_prev_value (w_prev_val),
                .i_used       (w_used[gi]),
                .i_next_value (w_next_val),
                .o_value      (w_val[gi])
            );
        end
    endgenerate

    // Result word: built from the row as it stands before the update.
    always_comb begin
        n_count             = r_count;
        n_res.removed_value = '0;
        n_res.head_value    = w_empty ? '0 : w_val[0];
        n_res.status        = ST_OK;
        if (i_cmd.word.command == CMD_INSERT) begin
            if (w_full) begin
                n_res.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (w_empty || (i_cmd.word.value < w_val[0])) begin
                    n_res.head_value = i_cmd.word.value;
                end
            end
        end else begin
            if (w_empty) begin
                n_res.status = ST_EMPTY;
            end else begin
                n_count             = r_count - CNT_W'(1);
                n_res.removed_value = w_val[0];
                // second cell becomes the head when an entry remains after the extract
                if (DEPTH > 1 && r_count > CNT_W'(1)) begin
                    n_res.head_value = w_val[(DEPTH > 1) ? 1 : 0];
                end else begin
                    n_res.head_value = '0;
                end
            end
        end
        n_res.entry_total = TOTAL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.word  = r_res;

endmodule

@@ tb/sv/bmhq_result_check.sv @@
// Checker for the min-heap queue: tracks the heap, predicts each result word and compares.
module bmhq_result_check
    import bmhq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  logic      i_cmd_ready,
    input  t_cmd_word i_cmd_word,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_res_word i_res_word,
    output int        o_errors,
    output int        o_pending
);

    // 1-based heap image: slot 1 is the root, slots 1..heap_size are live.
    logic signed [VALUE_W-1:0] heap_slots [1:DEPTH];
    int unsigned               heap_size = 0;
    t_res_word                 awaited_results [$];
    int                        error_total = 0;

    function automatic t_res_word apply_heap_command(input t_cmd_word w);
        t_res_word                 r;
        logic signed [VALUE_W-1:0] moving;
        int unsigned               hole;
        int unsigned               child;
        logic                      stop;
        r = '0;
        if (w.command == CMD_INSERT) begin
            if (heap_size >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                heap_size++;
                hole = heap_size;
                while (hole > 1 && w.value < heap_slots[hole / 2]) begin
                    heap_slots[hole] = heap_slots[hole / 2];
                    hole = hole / 2;
                end
                heap_slots[hole] = w.value;
            end
        end else if (heap_size == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.removed_value = heap_slots[1];
            moving = heap_slots[heap_size];
            heap_size--;
            hole = 1;
            stop = 1'b0;
            // walk down, smaller child wins, left child on a tie
            while (!stop && hole * 2 <= heap_size) begin
                child = hole * 2;
                if (child != heap_size && heap_slots[child + 1] < heap_slots[child])
                    child++;
                if (heap_slots[child] < moving) begin
                    heap_slots[hole] = heap_slots[child];
                    hole = child;
                end else begin
                    stop = 1'b1;
                end
            end
            heap_slots[hole] = moving;
        end
        r.head_value  = (heap_size != 0) ? heap_slots[1] : '0;
        r.entry_total = TOTAL_W'(heap_size);
        return r;
    endfunction

    task automatic flag_field(input string field, input logic signed [VALUE_W-1:0] want,
                              input logic signed [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res_word want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, i_res_word);
                    error_total++;
                end else begin
                    want = awaited_results.pop_front();
                    flag_field("removed_value", want.removed_value, i_res_word.removed_value);
                    flag_field("head_value", want.head_value, i_res_word.head_value);
                    flag_field("entry_total", VALUE_W'(want.entry_total),
                               VALUE_W'(i_res_word.entry_total));
                    flag_field("status", VALUE_W'(want.status), VALUE_W'(i_res_word.status));
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                awaited_results.push_back(apply_heap_command(i_cmd_word));
        end
        o_errors  <= error_total;
        o_pending <= awaited_results.size();
    end

endmodule

@@ tb/sv/binary_min_heap_queue_test.sv @@
// Top of the min-heap queue test: clock, reset, command stimulus, result stalls, verdict.
module binary_min_heap_queue_test;
    import bmhq_pkg::*;

    localparam int unsigned HEAP_DEPTH    = 64;
    localparam int unsigned RANDOM_WORDS  = 800;
    // Long receiver hold-off, started once enough words have gone in.
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned HOLD_CYCLES   = 400;
    // The result word is registered on acceptance; a few spare cycles catch strays.
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned LIMIT_CYCLES  = 200000;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmhq_cmd_if cmd_ch ();
    bmhq_res_if res_ch ();

    int          error_count;
    int          exp_pending;
    int unsigned words_sent  = 0;  // accepted command words so far
    int unsigned heap_fill   = 0;  // sender's own idea of the entry count
    int unsigned cycle_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    binary_min_heap_queue #(
        .DEPTH (HEAP_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bmhq_result_check #(
        .DEPTH (HEAP_DEPTH)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_ch.valid),
        .i_cmd_ready (cmd_ch.ready),
        .i_cmd_word  (cmd_ch.word),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res_word  (res_ch.word),
        .o_errors    (error_count),
        .o_pending   (exp_pending)
    );

    // Offer one command word and hold it until the block takes it. Valid stays
    // high on exit so back-to-back words never see a low-high glitch.
    task automatic send_word(input logic cmd, input logic signed [VALUE_W-1:0] val);
        t_cmd_word w;
        w.command = cmd;
        w.value   = val;
        cmd_ch.valid <= 1'b1;
        cmd_ch.word  <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        words_sent++;
        if (cmd == CMD_INSERT && heap_fill < HEAP_DEPTH)
            heap_fill++;
        else if (cmd == CMD_EXTRACT && heap_fill > 0)
            heap_fill--;
    endtask

    // Value mix: wide random for bit coverage, a narrow band for lots of
    // duplicates (ties in sift), the signed extremes and their neighbours, and 0/-1.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
            7:          return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            8:          return $urandom_range(0, 1) ? VAL_MAX - int'($urandom_range(0, 3))
                                                    : VAL_MIN + int'($urandom_range(0, 3));
            default:    return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    // Main stimulus: directed words, then fill/drain waves of random words.
    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        int unsigned edge_hits;
        int unsigned edge_target;
        logic        growing;
        logic        cmd;

        i_rst_n      <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.word  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty extract, signed extremes, zero/-1, equal keys, drain
        // past empty, then a run of ties under a smaller key.
        send_word(CMD_EXTRACT, $urandom);
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_INSERT, VAL_MAX);
        send_word(CMD_INSERT, VAL_MIN);
        send_word(CMD_INSERT, -32'sd1);
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_INSERT, VAL_MIN);
        repeat (7) send_word(CMD_EXTRACT, $urandom);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sd3);
        repeat (4) send_word(CMD_EXTRACT, $urandom);

        // Random waves: a growing phase is mostly inserts and lingers at full to
        // provoke rejections; a shrinking phase mostly extracts and pokes at empty.
        sent        = 0;
        growing     = 1'b1;
        edge_hits   = 0;
        edge_target = $urandom_range(1, 4);
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = 40;  // stretch with no idling at all
                gap   = 0;
            end else begin
                burst = $urandom_range(1, 12);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            for (int unsigned k = 0; k < burst; k++) begin
                if (growing)
                    cmd = ($urandom_range(0, 99) < 85) ? CMD_INSERT : CMD_EXTRACT;
                else
                    cmd = ($urandom_range(0, 99) < 15) ? CMD_INSERT : CMD_EXTRACT;
                send_word(cmd, pick_value());
                sent++;
                if (growing ? (heap_fill == HEAP_DEPTH) : (heap_fill == 0)) begin
                    edge_hits++;
                    if (edge_hits > edge_target) begin
                        growing     = !growing;
                        edge_hits   = 0;
                        edge_target = $urandom_range(1, 4);
                    end
                end else if ($urandom_range(0, 199) == 0) begin
                    growing = !growing;  // occasional early turn-around
                end
            end
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        cmd_ch.valid <= 1'b0;

        // Drain: wait for every predicted result, then a few quiet cycles.
        do @(posedge i_clk); while (exp_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("binary_min_heap_queue_test: done, clean");
        else
            $display("binary_min_heap_queue_test: done, errors");
        $finish;
    end

    // Result side: switches between stall patterns after each random-length span,
    // and once holds ready low for a long stretch so the block backs up.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned period;
        logic        held;
        logic        rdy;

        res_ch.ready <= 1'b0;
        held = 1'b0;
        forever begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 120);
            period = $urandom_range(2, 4);
            for (int unsigned k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (!held && words_sent >= HOLD_AFTER) begin
                    held = 1'b1;
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       rdy = 1'b1;                              // never stalls
                    1:       rdy = ($urandom_range(0, 3) != 0);       // light stalls
                    2:       rdy = ((k % period) == 0);               // fixed cadence
                    default: rdy = 1'($urandom_range(0, 1));          // heavy stalls
                endcase
                res_ch.ready <= rdy;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("binary_min_heap_queue_test: done, errors");
            $finish;
        end
    end

endmodule

@@ files.f @@
hdl/bmhq_pkg.sv
hdl/bmhq_if.sv
hdl/bmhq_cell.sv
hdl/binary_min_heap_queue.sv
tb/sv/bmhq_result_check.sv
tb/sv/binary_min_heap_queue_test.sv
